### src/ptst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptst_pkg: shared types and constants for the periodic timer slot table
// Slot table geometry, command and result codes, beat types and sequencer states.
// ----------------------------------------------------------------------------
package ptst_pkg;

   localparam int SLOTS       = 32;
   localparam int COUNT_BITS  = 16;
   localparam int PERIOD_BITS = 16;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int ID_BITS     = 5;
   localparam int KIND_BITS   = 3;
   localparam int CMP_BITS    = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
   localparam int ENTRY_BITS  = PERIOD_BITS + COUNT_BITS;

   localparam logic [1:0] FUNC_REGISTER = 2'd0;
   localparam logic [1:0] FUNC_REMOVE   = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_REGISTERED = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_FULL       = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_REMOVED    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_FIRED      = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_NO_FIRE    = 3'd4;

   typedef struct packed {
      logic [1:0]             func;
      logic [PERIOD_BITS-1:0] period;
      logic [ID_BITS-1:0]     slot_id;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [ID_BITS-1:0]   slot;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] next_count;
      logic                  fire;
   } count_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REG,
      ST_TICK,
      ST_DRAIN,
      ST_END
   } state_type;

endpackage

### src/ptst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptst_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ptst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/ptst_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptst_count_unit: shared slot count update
// Saturating increment of one slot count and compare against its period.
// ----------------------------------------------------------------------------
module ptst_count_unit
   import ptst_pkg::*;
(
   input  logic [COUNT_BITS-1:0]  count,
   input  logic [PERIOD_BITS-1:0] period,
   output count_result_type       result
);

   logic [COUNT_BITS-1:0] inc;
   logic [CMP_BITS-1:0]   inc_ext;
   logic [CMP_BITS-1:0]   period_ext;

   always_comb begin
      inc        = (count == {COUNT_BITS{1'b1}}) ? count : count + COUNT_BITS'(1);
      inc_ext    = CMP_BITS'(inc);
      period_ext = CMP_BITS'(period);
      result.fire       = (inc_ext >= period_ext);
      result.next_count = result.fire ? '0 : inc;
   end

endmodule

### src/periodic_timer_slot_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_slot_table_core: periodic timer slot table
// Register, remove and tick commands over a table of periodic timer slots.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. Results leave
//   on rsp_data marked by a one-cycle rsp_valid strobe; the receiver cannot
//   hold them off. rsp_data.last marks the final result beat of a command.
//   Remove: one result, the cycle after the command; busy stays low.
//   Register: slots are tested one per cycle from slot 1 upward; the result
//   names the first free slot, or reports KIND_FULL when the search reaches
//   slot SLOTS-1 and finds it taken.
//   Tick: the slot RAM is swept one slot per cycle through the shared count
//   unit (read, update, write back): slots 1 to SLOTS-1 are read, then come a
//   drain state and a close-out state, and the final result beat follows the
//   close-out. Fire beats leave during the sweep, each one held until the next
//   fire is detected; the last one or the no-fire beat leaves at the end.
//   Reset clears the active mask and the sequencer; the slot RAM needs no
//   clearing since a slot is written when it is registered.
// ----------------------------------------------------------------------------
module periodic_timer_slot_table_core
   import ptst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(SLOTS - 1);
   localparam logic [SLOT_BITS-1:0] FIRST_SLOT = SLOT_BITS'(1);

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   idx_ff, idx_in;
   logic [SLOTS-1:0]       active_ff, active_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   pipe_vld_ff, pipe_vld_in;
   logic [SLOT_BITS-1:0]   pipe_slot_ff, pipe_slot_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [SLOT_BITS-1:0]   pend_slot_ff, pend_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   ram_wr_en;
   logic [SLOT_BITS-1:0]   ram_wr_addr;
   logic [ENTRY_BITS-1:0]  ram_wr_data;
   logic [SLOT_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0]  ram_rd_data;
   logic [PERIOD_BITS-1:0] rd_period;
   logic [COUNT_BITS-1:0]  rd_count;
   count_result_type       cnt_res;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rd_period = ram_rd_data[ENTRY_BITS-1:COUNT_BITS];
   assign rd_count  = ram_rd_data[COUNT_BITS-1:0];

   ptst_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ptst_count_unit u_count (
      .count  (rd_count),
      .period (rd_period),
      .result (cnt_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.func == FUNC_REGISTER) begin
                  state_in = ST_REG;
               end else if (req_data.func == FUNC_TICK) begin
                  state_in = ST_TICK;
               end
            end
         end
         ST_REG: begin
            if (!active_ff[idx_ff] || idx_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_END;
         ST_END:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in       = idx_ff;
      active_in    = active_ff;
      period_in    = period_ff;
      pipe_vld_in  = 1'b0;
      pipe_slot_in = idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_slot_in = pend_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pipe_slot_ff;
      ram_wr_data  = {rd_period, cnt_res.next_count};
      ram_rd_addr  = idx_ff;

      // write-back stage of the tick sweep
      if (pipe_vld_ff && active_ff[pipe_slot_ff]) begin
         ram_wr_en = 1'b1;
         if (cnt_res.fire) begin
            if (pend_vld_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_FIRED, slot: ID_BITS'(pend_slot_ff), last: 1'b0};
            end
            pend_vld_in  = 1'b1;
            pend_slot_in = pipe_slot_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               period_in = req_data.period;
               idx_in    = FIRST_SLOT;
               if (req_data.func == FUNC_REMOVE) begin
                  if (32'(req_data.slot_id) < SLOTS) begin
                     active_in[req_data.slot_id] = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: KIND_REMOVED, slot: req_data.slot_id, last: 1'b1};
               end
            end
         end
         ST_REG: begin
            if (!active_ff[idx_ff]) begin
               active_in[idx_ff] = 1'b1;
               ram_wr_en         = 1'b1;
               ram_wr_addr       = idx_ff;
               ram_wr_data       = {period_ff, {COUNT_BITS{1'b0}}};
               rsp_valid_in      = 1'b1;
               rsp_in = '{kind: KIND_REGISTERED, slot: ID_BITS'(idx_ff), last: 1'b1};
            end else if (idx_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_FULL, slot: '0, last: 1'b1};
            end else begin
               idx_in = idx_ff + FIRST_SLOT;
            end
         end
         ST_TICK: begin
            pipe_vld_in  = 1'b1;
            pipe_slot_in = idx_ff;
            idx_in       = idx_ff + FIRST_SLOT;
         end
         ST_DRAIN: begin
         end
         ST_END: begin
            rsp_valid_in = 1'b1;
            pend_vld_in  = 1'b0;
            if (pend_vld_ff) begin
               rsp_in = '{kind: KIND_FIRED, slot: ID_BITS'(pend_slot_ff), last: 1'b1};
            end else begin
               rsp_in = '{kind: KIND_NO_FIRE, slot: '0, last: 1'b1};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         pipe_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pipe_vld_ff  <= pipe_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      period_ff    <= period_in;
      pipe_slot_ff <= pipe_slot_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   a_slot0_never_active: assert property (@(posedge clock) disable iff (reset)
      !active_ff[0])
      else $error("slot 0 became active");

   a_end_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_END |-> !pipe_vld_ff)
      else $error("tick close-out with sweep still in flight");

   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> busy)
      else $error("non-final result beat while idle");

   a_register_scans: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.func == FUNC_REGISTER |=> state_ff == ST_REG && idx_ff == FIRST_SLOT)
      else $error("register command did not start the slot search at slot 1");

endmodule
